// ===== hw/rtl/text_console_writer_top_macros.svh =====
// Assertion macros used by the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TCW_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// Shared request codes, field widths and cell constants of the console writer.
package tcw_pkg;

    localparam int REQ_W     = 3;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int ARG_W     = 8;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int CELL_W    = 2 * CHAR_W;

    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [CHAR_W-1:0] t_byte;

    localparam t_req REQ_PUT   = 3'd0;
    localparam t_req REQ_GOTO  = 3'd1;
    localparam t_req REQ_MOVE  = 3'd2;
    localparam t_req REQ_CLEAR = 3'd3;
    localparam t_req REQ_READ  = 3'd4;

    localparam t_byte NEWLINE_CODE = 8'h0a;
    localparam t_byte BLANK_CHAR   = 8'h00;
    localparam t_byte BLANK_ATTR   = 8'h07;

endpackage

// ===== hw/rtl/text_console_writer_top.sv =====
// Top level of the text console writer: cell memory, cursor and request sequencer.
//
// Usage: one request transaction enters on i_in_valid / o_in_ready and yields
// exactly one result transaction on o_out_valid / i_out_ready, in order.
// Every result carries the cursor after the request; a read request also
// carries the character and attribute bytes of the addressed cell.
// Cell storage is one simple dual-port memory of COLS*ROWS 16-bit words
// with a registered read; the sequencer owns both ports.
// Path from acceptance to the result in the output register:
//   put (no scroll), unused codes 5..7   next cycle, one put per cycle while each
//                                        result is taken
//   read                                 memory read register, then ST_READ
//   goto / move                          three-stage reciprocal modulo units
//   put that scrolls                     ST_SCROLL over all COLS*ROWS cells, one
//                                        memory word moved per cycle, then ST_TAIL
//   clear                                ST_WIPE over all COLS*ROWS cells
// One request is in flight at a time. After reset the block runs a clearing
// pass over all COLS*ROWS cells with o_in_ready low.
// A stalled receiver holds the result in the output register; a new request
// is taken only when that register is empty or drains in the same cycle.
module text_console_writer_top #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tcw_pkg::REQ_W-1:0]      i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]    i_bg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]    i_fg_color,
    input  logic signed [tcw_pkg::ARG_W-1:0] i_col_arg,
    input  logic signed [tcw_pkg::ARG_W-1:0] i_row_arg,
    input  logic [tcw_pkg::IDX_W-1:0]      i_cell_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tcw_pkg::POS_W-1:0]      o_cursor_pos,
    output logic [tcw_pkg::COL_OUT_W-1:0]  o_cursor_col_out,
    output logic [tcw_pkg::ROW_OUT_W-1:0]  o_cursor_row_out,
    output logic [tcw_pkg::CHAR_W-1:0]     o_read_char,
    output logic [tcw_pkg::CHAR_W-1:0]     o_read_attr
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CW     = tcw_pkg::CELL_W;
    // Width of offset position sums for goto / move
    localparam int MOD_C  = $clog2(2 * COLS + 255);
    localparam int MOD_R  = $clog2(2 * ROWS + 255);
    localparam int MOD_W  = (MOD_C > MOD_R) ? MOD_C : MOD_R;
    // Multiples of COLS / ROWS that lift any negative argument to >= 0
    localparam int COL_OFS = COLS * ((128 + COLS - 1) / COLS);
    localparam int ROW_OFS = ROWS * ((128 + ROWS - 1) / ROWS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WIPE   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_MOD    = 3'd5;

    // Cell memory: {char, attr}
    logic [CW-1:0] mem [CELLS];

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_wipe_rsp, n_wipe_rsp;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_wr_last, n_wr_last;
    logic              r_rd_oob, n_rd_oob;
    logic [CW-1:0]     r_rd_data;
    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [CW-1:0]     r_out_cell;

    logic              w_accept;
    logic              w_finish;
    logic              w_we;
    logic [ADDR_W-1:0] w_wa;
    logic [CW-1:0]     w_wd;
    logic [ADDR_W-1:0] w_ra;
    logic [CW-1:0]     w_rsp_cell;
    logic [ADDR_W-1:0] w_cur_pos;
    logic [ADDR_W-1:0] w_out_pos;
    logic [COL_W:0]    w_col_inc;
    logic [ROW_W:0]    w_row_inc;
    logic              w_below_last;
    logic              w_mod_start;
    logic [MOD_W-1:0]  w_col_seed;
    logic [MOD_W-1:0]  w_row_seed;
    logic              w_col_done;
    logic              w_row_done;
    logic [COL_W-1:0]  w_col_res;
    logic [ROW_W-1:0]  w_row_res;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_cur_pos    = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);
    assign w_col_inc    = {1'b0, r_col} + 1'b1;
    assign w_row_inc    = {1'b0, r_row} + 1'b1;
    assign w_below_last = r_idx < ADDR_W'(CELLS - COLS);

    // Goto starts from zero, move from the cursor; offset keeps the sum non-negative
    assign w_col_seed = ((i_req_type == tcw_pkg::REQ_GOTO) ? '0 : MOD_W'(r_col))
                      + {{(MOD_W - tcw_pkg::ARG_W){i_col_arg[tcw_pkg::ARG_W-1]}}, i_col_arg}
                      + MOD_W'(COL_OFS);
    assign w_row_seed = ((i_req_type == tcw_pkg::REQ_GOTO) ? '0 : MOD_W'(r_row))
                      + {{(MOD_W - tcw_pkg::ARG_W){i_row_arg[tcw_pkg::ARG_W-1]}}, i_row_arg}
                      + MOD_W'(ROW_OFS);

    tcw_mod_unit #(
        .M     (COLS),
        .VAL_W (MOD_W),
        .RES_W (COL_W)
    ) u_col_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mod_start),
        .i_value  (w_col_seed),
        .o_done   (w_col_done),
        .o_result (w_col_res)
    );

    tcw_mod_unit #(
        .M     (ROWS),
        .VAL_W (MOD_W),
        .RES_W (ROW_W)
    ) u_row_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mod_start),
        .i_value  (w_row_seed),
        .o_done   (w_row_done),
        .o_result (w_row_res)
    );

    // Sequencer: memory port control, cursor update, result timing
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wipe_rsp  = r_wipe_rsp;
        n_col       = r_col;
        n_row       = r_row;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_idx;
        n_wr_last   = !w_below_last;
        n_rd_oob    = r_rd_oob;
        w_finish    = 1'b0;
        w_mod_start = 1'b0;
        w_we        = 1'b0;
        w_wa        = r_wr_addr;
        w_wd        = r_wr_last ? {tcw_pkg::BLANK_CHAR, r_rd_data[tcw_pkg::CHAR_W-1:0]}
                                : r_rd_data;
        w_ra        = ADDR_W'(i_cell_index);
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req_type)
                        tcw_pkg::REQ_PUT: begin
                            if (i_char_code != tcw_pkg::NEWLINE_CODE) begin
                                w_we = 1'b1;
                                w_wa = w_cur_pos;
                                w_wd = {i_char_code, i_bg_color, i_fg_color};
                            end
                            if (i_char_code == tcw_pkg::NEWLINE_CODE ||
                                w_col_inc == (COL_W + 1)'(COLS)) begin
                                n_col = '0;
                                if (w_row_inc == (ROW_W + 1)'(ROWS)) begin
                                    // bottom edge: row stays, screen scrolls
                                    n_state = ST_SCROLL;
                                    n_idx   = '0;
                                end else begin
                                    n_row    = w_row_inc[ROW_W-1:0];
                                    w_finish = 1'b1;
                                end
                            end else begin
                                n_col    = w_col_inc[COL_W-1:0];
                                w_finish = 1'b1;
                            end
                        end
                        tcw_pkg::REQ_GOTO, tcw_pkg::REQ_MOVE: begin
                            w_mod_start = 1'b1;
                            n_state     = ST_MOD;
                        end
                        tcw_pkg::REQ_CLEAR: begin
                            n_state    = ST_WIPE;
                            n_idx      = '0;
                            n_wipe_rsp = 1'b1;
                        end
                        tcw_pkg::REQ_READ: begin
                            n_rd_oob = 32'(i_cell_index) >= CELLS;
                            n_state  = ST_READ;
                        end
                        default: begin
                            w_finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_WIPE: begin
                w_we = 1'b1;
                w_wa = r_idx;
                w_wd = {tcw_pkg::BLANK_CHAR, tcw_pkg::BLANK_ATTR};
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state    = ST_IDLE;
                    w_finish   = r_wipe_rsp;
                    n_wipe_rsp = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SCROLL: begin
                // read one row ahead (the last row reads itself), write back in the next cycle
                w_we      = r_wr_pend;
                w_ra      = w_below_last ? r_idx + ADDR_W'(COLS) : r_idx;
                n_wr_pend = 1'b1;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_TAIL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TAIL: begin
                w_we     = r_wr_pend;
                w_finish = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_READ: begin
                w_finish = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_MOD: begin
                if (w_col_done && w_row_done) begin
                    n_col    = w_col_res;
                    n_row    = w_row_res;
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_rsp_cell = (r_state == ST_READ && !r_rd_oob) ? r_rd_data : '0;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_idx       <= '0;
            r_wipe_rsp  <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_wipe_rsp <= n_wipe_rsp;
            r_col      <= n_col;
            r_row      <= n_row;
            r_wr_pend  <= n_wr_pend;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_wr_last <= n_wr_last;
        r_rd_oob  <= n_rd_oob;
        if (w_finish) begin
            r_out_col  <= n_col;
            r_out_row  <= n_row;
            r_out_cell <= w_rsp_cell;
        end
    end

    // Cell memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd_data <= mem[w_ra];
    end

    assign w_out_pos        = ADDR_W'(r_out_row) * ADDR_W'(COLS) + ADDR_W'(r_out_col);
    assign o_out_valid      = r_out_valid;
    assign o_cursor_pos     = tcw_pkg::POS_W'(w_out_pos);
    assign o_cursor_col_out = tcw_pkg::COL_OUT_W'(r_out_col);
    assign o_cursor_row_out = tcw_pkg::ROW_OUT_W'(r_out_row);
    assign o_read_char      = r_out_cell[CW-1:tcw_pkg::CHAR_W];
    assign o_read_attr      = r_out_cell[tcw_pkg::CHAR_W-1:0];

endmodule

// ===== hw/rtl/tcw_mod_unit.sv =====
// Modulo of a non-negative value by a constant, by registered reciprocal multiplication.
module tcw_mod_unit #(
    parameter int M     = 80,
    parameter int VAL_W = 9,
    parameter int RES_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_done,
    output logic [RES_W-1:0] o_result
);

    // Quotient by multiply and shift; exact for every VAL_W-bit value
    localparam int SHIFT  = VAL_W + $clog2(M);
    localparam int PROD_W = VAL_W + SHIFT;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'(((1 << SHIFT) + M - 1) / M);

    logic              r_mul_vld;
    logic              r_sub_vld;
    logic              r_done;
    logic [VAL_W-1:0]  r_val;
    logic [VAL_W-1:0]  r_quo;
    logic [VAL_W-1:0]  r_rem;
    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(r_val) * PROD_W'(RECIP);

    // Stage valids: load, quotient, remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
            r_sub_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_mul_vld <= i_start;
            r_sub_vld <= r_mul_vld;
            r_done    <= r_sub_vld;
        end
    end

    // Datapath; r_val holds until the remainder is taken
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_mul_vld) begin
            r_quo <= w_prod[PROD_W-1:SHIFT];
        end
        if (r_sub_vld) begin
            r_rem <= r_val - VAL_W'(r_quo * VAL_W'(M));
        end
    end

    assign o_done   = r_done;
    assign o_result = RES_W'(r_rem);

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// Port-level assertion checker for the console writer, bound to the top level.
`include "text_console_writer_top_macros.svh"

module tcw_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic [tcw_pkg::REQ_W-1:0]        i_req_type,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [tcw_pkg::POS_W-1:0]        o_cursor_pos,
    input logic [tcw_pkg::COL_OUT_W-1:0]    o_cursor_col_out,
    input logic [tcw_pkg::ROW_OUT_W-1:0]    o_cursor_row_out,
    input logic [tcw_pkg::CHAR_W-1:0]       o_read_char,
    input logic [tcw_pkg::CHAR_W-1:0]       o_read_attr
);

    tcw_pkg::t_req             r_last_req;
    logic                      w_in_xact;
    logic                      w_non_read;
    logic [tcw_pkg::POS_W-1:0] w_pos_calc;

    assign w_in_xact  = i_in_valid && o_in_ready;
    assign w_non_read = o_out_valid && (r_last_req != tcw_pkg::REQ_READ);
    assign w_pos_calc = tcw_pkg::POS_W'(32'(o_cursor_row_out) * COLS + 32'(o_cursor_col_out));

    // Request type of the transaction whose result is pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_req <= tcw_pkg::REQ_PUT;
        end else if (w_in_xact) begin
            r_last_req <= i_req_type;
        end
    end

    // A held result stays offered
    `TCW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A request is only taken when the result register drains or is empty
    `TCW_ASSERT_IMPL(a_accept_free, w_in_xact && o_out_valid, i_out_ready)

    // Reported column stays on the screen
    `TCW_ASSERT_IMPL(a_col_range, o_out_valid, 32'(o_cursor_col_out) < COLS)

    // Linear position agrees with row and column
    `TCW_ASSERT_IMPL(a_pos_match, o_out_valid && (ROWS <= 32), o_cursor_pos == w_pos_calc)

    // Only read requests return cell bytes
    `TCW_ASSERT_IMPL(a_read_zero, w_non_read, (o_read_char == '0) && (o_read_attr == '0))

endmodule

bind text_console_writer_top tcw_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcw_checker (.*);

// ===== verif/text_console_writer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the text console writer: directed table, then random requests.
module testbench;

    localparam int SCREEN_COLS   = 80;
    localparam int SCREEN_ROWS   = 25;
    localparam int CELL_COUNT    = SCREEN_COLS * SCREEN_ROWS;
    localparam int RANDOM_ITEMS  = 1250;
    // longest single request (a scrolling put) plus margin
    localparam int SETTLE_CYCLES = 2100;
    localparam int TIMEOUT_NS    = 200_000_000;
    localparam int IDLE_PCT      = 34;

    // request codes the block treats as no-ops
    localparam tcw_pkg::t_req REQ_SPARE_LO = 3'd5;
    localparam tcw_pkg::t_req REQ_SPARE_HI = 3'd7;

    typedef struct {
        logic [tcw_pkg::POS_W-1:0]     pos;
        logic [tcw_pkg::COL_OUT_W-1:0] col;
        logic [tcw_pkg::ROW_OUT_W-1:0] row;
        tcw_pkg::t_byte                rd_char;
        tcw_pkg::t_byte                rd_attr;
    } t_cursor_report;

    typedef struct {
        tcw_pkg::t_req                    req;
        tcw_pkg::t_byte                   ch;
        logic [tcw_pkg::COLOR_W-1:0]      bg;
        logic [tcw_pkg::COLOR_W-1:0]      fg;
        logic signed [tcw_pkg::ARG_W-1:0] col_arg;
        logic signed [tcw_pkg::ARG_W-1:0] row_arg;
        logic [tcw_pkg::IDX_W-1:0]        idx;
        bit                               pinned;   // expected report typed into the table
        t_cursor_report                   pin;
    } t_console_req;

    // DUT signals
    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_in_valid   = 1'b0;
    logic                             o_in_ready;
    logic [tcw_pkg::REQ_W-1:0]        i_req_type   = '0;
    logic [tcw_pkg::CHAR_W-1:0]       i_char_code  = '0;
    logic [tcw_pkg::COLOR_W-1:0]      i_bg_color   = '0;
    logic [tcw_pkg::COLOR_W-1:0]      i_fg_color   = '0;
    logic signed [tcw_pkg::ARG_W-1:0] i_col_arg    = '0;
    logic signed [tcw_pkg::ARG_W-1:0] i_row_arg    = '0;
    logic [tcw_pkg::IDX_W-1:0]        i_cell_index = '0;
    logic                             o_out_valid;
    logic                             i_out_ready  = 1'b0;
    logic [tcw_pkg::POS_W-1:0]        o_cursor_pos;
    logic [tcw_pkg::COL_OUT_W-1:0]    o_cursor_col_out;
    logic [tcw_pkg::ROW_OUT_W-1:0]    o_cursor_row_out;
    logic [tcw_pkg::CHAR_W-1:0]       o_read_char;
    logic [tcw_pkg::CHAR_W-1:0]       o_read_attr;

    // predictor state
    tcw_pkg::t_byte screen_char [CELL_COUNT];
    tcw_pkg::t_byte screen_attr [CELL_COUNT];
    int             cur_col;
    int             cur_row;

    t_console_req   directed_steps[$];
    t_cursor_report due_reports[$];
    t_console_req   pending_req;
    bit             steady_run     = 1'b0;
    int             mismatch_count = 0;

    text_console_writer_top #(
        .COLS (SCREEN_COLS),
        .ROWS (SCREEN_ROWS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_char_code      (i_char_code),
        .i_bg_color       (i_bg_color),
        .i_fg_color       (i_fg_color),
        .i_col_arg        (i_col_arg),
        .i_row_arg        (i_row_arg),
        .i_cell_index     (i_cell_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_pos     (o_cursor_pos),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out),
        .o_read_char      (o_read_char),
        .o_read_attr      (o_read_attr)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Screen predictor
    // ---------------------------------------------------------------
    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_char[i] = tcw_pkg::BLANK_CHAR;
            screen_attr[i] = tcw_pkg::BLANK_ATTR;
        end
    endfunction

    // non-negative remainder
    function automatic int wrap_mod(int v, int m);
        int r;
        r = v % m;
        if (r < 0) r += m;
        return r;
    endfunction

    function automatic t_cursor_report advance_console(t_console_req rq);
        t_cursor_report res;
        int slot;
        res = '{default: '0};
        unique case (rq.req)
            tcw_pkg::REQ_PUT: begin
                if (rq.ch != tcw_pkg::NEWLINE_CODE) begin
                    slot = cur_row * SCREEN_COLS + cur_col;
                    screen_char[slot] = rq.ch;
                    screen_attr[slot] = {rq.bg, rq.fg};
                    cur_col++;
                end else begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_col >= SCREEN_COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // scroll: rows shift up, last row chars blanked, attrs kept
                if (cur_row >= SCREEN_ROWS) begin
                    for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++) begin
                        screen_char[i] = screen_char[i + SCREEN_COLS];
                        screen_attr[i] = screen_attr[i + SCREEN_COLS];
                    end
                    for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++) begin
                        screen_char[i] = tcw_pkg::BLANK_CHAR;
                    end
                    cur_row = SCREEN_ROWS - 1;
                end
            end
            tcw_pkg::REQ_GOTO: begin
                cur_col = wrap_mod(int'(rq.col_arg), SCREEN_COLS);
                cur_row = wrap_mod(int'(rq.row_arg), SCREEN_ROWS);
            end
            tcw_pkg::REQ_MOVE: begin
                cur_col = wrap_mod(cur_col + int'(rq.col_arg), SCREEN_COLS);
                cur_row = wrap_mod(cur_row + int'(rq.row_arg), SCREEN_ROWS);
            end
            tcw_pkg::REQ_CLEAR: begin
                blank_screen();
            end
            tcw_pkg::REQ_READ: begin
                if (rq.idx < CELL_COUNT) begin
                    res.rd_char = screen_char[rq.idx];
                    res.rd_attr = screen_attr[rq.idx];
                end
            end
            default: ;
        endcase
        res.pos = tcw_pkg::POS_W'(cur_row * SCREEN_COLS + cur_col);
        res.col = tcw_pkg::COL_OUT_W'(cur_col);
        res.row = tcw_pkg::ROW_OUT_W'(cur_row);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Directed table helpers
    // ---------------------------------------------------------------
    function automatic void add_step(tcw_pkg::t_req req, int ch, int bg, int fg,
                                     int ca, int ra, int idx);
        t_console_req rq;
        rq.req     = req;
        rq.ch      = tcw_pkg::CHAR_W'(ch);
        rq.bg      = tcw_pkg::COLOR_W'(bg);
        rq.fg      = tcw_pkg::COLOR_W'(fg);
        rq.col_arg = tcw_pkg::ARG_W'(ca);
        rq.row_arg = tcw_pkg::ARG_W'(ra);
        rq.idx     = tcw_pkg::IDX_W'(idx);
        rq.pinned  = 1'b0;
        rq.pin     = '{default: '0};
        directed_steps.push_back(rq);
    endfunction

    // type in the expected report of the last row
    function automatic void pin_report(int pos, int col, int row, int rc, int ratt);
        int last;
        last = directed_steps.size() - 1;
        directed_steps[last].pinned      = 1'b1;
        directed_steps[last].pin.pos     = tcw_pkg::POS_W'(pos);
        directed_steps[last].pin.col     = tcw_pkg::COL_OUT_W'(col);
        directed_steps[last].pin.row     = tcw_pkg::ROW_OUT_W'(row);
        directed_steps[last].pin.rd_char = tcw_pkg::CHAR_W'(rc);
        directed_steps[last].pin.rd_attr = tcw_pkg::CHAR_W'(ratt);
    endfunction

    // ---------------------------------------------------------------
    // Random request generator
    // ---------------------------------------------------------------
    function automatic t_console_req draw_request();
        t_console_req rq;
        int pick;
        int near;
        // every field random first, so ignored fields carry noise
        rq.req     = tcw_pkg::REQ_PUT;
        rq.ch      = tcw_pkg::CHAR_W'($urandom_range(255));
        rq.bg      = tcw_pkg::COLOR_W'($urandom_range(15));
        rq.fg      = tcw_pkg::COLOR_W'($urandom_range(15));
        rq.col_arg = tcw_pkg::ARG_W'($urandom_range(255));
        rq.row_arg = tcw_pkg::ARG_W'($urandom_range(255));
        rq.idx     = tcw_pkg::IDX_W'($urandom_range(2047));
        rq.pinned  = 1'b0;
        rq.pin     = '{default: '0};
        pick = $urandom_range(99);
        if (pick < 55) begin
            if ($urandom_range(99) < 8) rq.ch = tcw_pkg::NEWLINE_CODE;
        end else if (pick < 65) begin
            rq.req = tcw_pkg::REQ_GOTO;
            // bias toward the bottom row so scrolls happen
            if ($urandom_range(99) < 25)
                rq.row_arg = ($urandom_range(1) != 0) ? tcw_pkg::ARG_W'(SCREEN_ROWS - 1)
                                                      : tcw_pkg::ARG_W'(-1);
        end else if (pick < 75) begin
            rq.req = tcw_pkg::REQ_MOVE;
            if ($urandom_range(99) < 30) begin
                rq.col_arg = tcw_pkg::ARG_W'($urandom_range(4) - 2);
                rq.row_arg = tcw_pkg::ARG_W'($urandom_range(4) - 2);
            end
        end else if (pick < 77) begin
            rq.req = tcw_pkg::REQ_CLEAR;
        end else if (pick < 97) begin
            rq.req = tcw_pkg::REQ_READ;
            pick = $urandom_range(99);
            if (pick < 50) begin
                // just behind the cursor, where recent puts landed
                near = cur_row * SCREEN_COLS + cur_col - $urandom_range(40);
                rq.idx = tcw_pkg::IDX_W'((near < 0) ? 0 : near);
            end else if (pick < 60) begin
                rq.idx = tcw_pkg::IDX_W'($urandom_range(2047, CELL_COUNT));
            end else begin
                rq.idx = tcw_pkg::IDX_W'($urandom_range(CELL_COUNT - 1));
            end
        end else begin
            rq.req = tcw_pkg::t_req'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
        end
        return rq;
    endfunction

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    task automatic send_request(input t_console_req rq);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= rq.req;
        i_char_code  <= rq.ch;
        i_bg_color   <= rq.bg;
        i_fg_color   <= rq.fg;
        i_col_arg    <= rq.col_arg;
        i_row_arg    <= rq.row_arg;
        i_cell_index <= rq.idx;
        pending_req  <= rq;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // hold off the sender until every report is back
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_reports.size() != 0);
    endtask

    task automatic log_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    // Result receiver: random backpressure
    always @(posedge i_clk) begin
        i_out_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    // Prediction on request transaction, check on result transaction
    always @(posedge i_clk) begin : scoreboard
        t_cursor_report want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            want = advance_console(pending_req);
            due_reports.push_back(pending_req.pinned ? pending_req.pin : want);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_reports.size() == 0) begin
                log_mismatch("result transaction with no request outstanding");
            end else begin
                want = due_reports.pop_front();
                if (o_cursor_pos !== want.pos)
                    log_mismatch($sformatf("cursor_pos got %0d want %0d",
                                           o_cursor_pos, want.pos));
                if (o_cursor_col_out !== want.col)
                    log_mismatch($sformatf("cursor_col got %0d want %0d",
                                           o_cursor_col_out, want.col));
                if (o_cursor_row_out !== want.row)
                    log_mismatch($sformatf("cursor_row got %0d want %0d",
                                           o_cursor_row_out, want.row));
                if (o_read_char !== want.rd_char)
                    log_mismatch($sformatf("read_char got %h want %h",
                                           o_read_char, want.rd_char));
                if (o_read_attr !== want.rd_attr)
                    log_mismatch($sformatf("read_attr got %h want %h",
                                           o_read_attr, want.rd_attr));
            end
        end
    end

    // Main sequence
    initial begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;

        // cells after reset, inside and past the screen
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);        pin_report(0, 0, 0, 0, 7);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 1999);     pin_report(0, 0, 0, 0, 7);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 2047);     pin_report(0, 0, 0, 0, 0);
        // extreme character and colors, then zero byte
        add_step(tcw_pkg::REQ_PUT, 8'hff, 15, 15, 0, 0, 0);   pin_report(1, 1, 0, 0, 0);
        add_step(tcw_pkg::REQ_PUT, 8'h00, 0, 0, 0, 0, 0);     pin_report(2, 2, 0, 0, 0);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);        pin_report(2, 2, 0, 8'hff, 8'hff);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 1);        pin_report(2, 2, 0, 0, 0);
        add_step(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 3, 4, 0, 0, 0);
        pin_report(80, 0, 1, 0, 0);
        // negative goto lands on the last cell, put there wraps and scrolls
        add_step(tcw_pkg::REQ_GOTO, 0, 0, 0, -1, -1, 0);      pin_report(1999, 79, 24, 0, 0);
        add_step(tcw_pkg::REQ_PUT, 8'h41, 1, 2, 0, 0, 0);     pin_report(1920, 0, 24, 0, 0);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 1999);     pin_report(1920, 0, 24, 0, 8'h12);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 1919);
        pin_report(1920, 0, 24, 8'h41, 8'h12);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);        pin_report(1920, 0, 24, 0, 7);
        // goto and move at argument extremes
        add_step(tcw_pkg::REQ_GOTO, 0, 0, 0, 127, 127, 0);    pin_report(207, 47, 2, 0, 0);
        add_step(tcw_pkg::REQ_GOTO, 0, 0, 0, -128, -128, 0);  pin_report(1792, 32, 22, 0, 0);
        add_step(tcw_pkg::REQ_MOVE, 0, 0, 0, 127, 127, 0);    pin_report(1999, 79, 24, 0, 0);
        add_step(tcw_pkg::REQ_MOVE, 0, 0, 0, -128, -128, 0);  pin_report(1711, 31, 21, 0, 0);
        add_step(tcw_pkg::REQ_MOVE, 0, 0, 0, 0, 0, 0);
        // newline on the bottom row scrolls
        add_step(tcw_pkg::REQ_GOTO, 0, 0, 0, 5, 24, 0);       pin_report(1925, 5, 24, 0, 0);
        add_step(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 0, 0, 0, 0, 0);
        pin_report(1920, 0, 24, 0, 0);
        // unused codes change nothing
        add_step(REQ_SPARE_LO, 8'hff, 15, 15, -1, -1, 2047);  pin_report(1920, 0, 24, 0, 0);
        add_step(REQ_SPARE_HI, 8'hff, 15, 15, -1, -1, 0);     pin_report(1920, 0, 24, 0, 0);
        // clear keeps the cursor
        add_step(tcw_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0);       pin_report(1920, 0, 24, 0, 0);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 1919);     pin_report(1920, 0, 24, 0, 7);
        add_step(tcw_pkg::REQ_GOTO, 0, 0, 0, 10, 3, 0);
        add_step(tcw_pkg::REQ_PUT, 8'h5a, 10, 5, 0, 0, 0);
        add_step(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 250);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k]) send_request(directed_steps[k]);
        drain_reports();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // a long stretch with no idling on either side
            steady_run = (n >= 400 && n < 600);
            if (n == 800) drain_reports();
            send_request(draw_request());
        end
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && due_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== text_console_writer_top.f =====
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_mod_unit.sv
hw/rtl/text_console_writer_top.sv
hw/rtl/tcw_checker.sv
verif/text_console_writer_tb.sv
